// File: rtl/ordered_composition_counter_macros.svh
// Assertion macros shared by the ordered composition counter RTL.
// Depends on nothing; expects i_clk and i_rst_n in the including module.
`ifndef ORDERED_COMPOSITION_COUNTER_MACROS_SVH
`define ORDERED_COMPOSITION_COUNTER_MACROS_SVH

// Same-cycle implication, sampled at the rising clock edge outside reset.
`define OCC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled at the rising clock edge outside reset.
`define OCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/occ_pkg.sv
// Package for the ordered composition counter: sizes, widths and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package occ_pkg;

    localparam int MAX_PARTS  = 16;
    localparam int MAX_TARGET = 1023;

    localparam int VAL_W = 10;  // part value field
    localparam int TGT_W = 10;  // target sum field
    localparam int WAY_W = 32;  // count table entry and result

    localparam int IDX_W = $clog2(MAX_TARGET + 1);
    localparam int CNT_W = $clog2(MAX_PARTS + 1);
    localparam int K_W   = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
    localparam int EW    = (IDX_W > VAL_W) ? IDX_W : VAL_W;

    typedef struct packed {
        logic load;    // input transaction accepted
        logic init;    // seed entry zero, restart the outer index
        logic issue;   // examine one stored part, launch a table read
        logic write;   // store the accumulated entry, advance the index
        logic finish;  // capture the result, clear the part set
    } t_dp_cmd;

    typedef struct packed {
        logic target_zero;
        logic target_big;
        logic count_zero;
        logic k_last;
        logic i_last;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: rtl/occ_ctrl.sv
// Sequencer for the ordered composition counter.
// Depends on occ_pkg and ordered_composition_counter_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "ordered_composition_counter_macros.svh"

module occ_ctrl
    import occ_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire logic    i_last_part,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd,
    output logic         o_busy,
    output logic         o_valid
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_INIT,
        S_ISSUE,
        S_WAIT,
        S_WRITE
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   accept;

    assign accept = i_start && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        o_cmd   = '0;
        o_cmd.load = accept;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_last_part) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.target_zero || i_sts.target_big || i_sts.count_zero) begin
                    o_cmd.finish = 1'b1;
                    n_valid      = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = S_ISSUE;
            end
            S_ISSUE: begin
                o_cmd.issue = 1'b1;
                if (i_sts.k_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                // last read of this entry lands in the accumulator
                n_state = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
                if (i_sts.i_last) begin
                    o_cmd.finish = 1'b1;
                    n_valid      = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_ISSUE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

    `OCC_ASSERT_NOW(a_valid_idle, r_valid, r_state == S_IDLE, "result shown while busy")
    `OCC_ASSERT_NEXT(a_valid_pulse, r_valid, !r_valid, "result strobe longer than a cycle")
    `OCC_ASSERT_NEXT(a_last_busy, accept && i_last_part, o_busy, "final part did not start count")

endmodule

`default_nettype wire

// File: rtl/occ_datapath.sv
// Datapath: part store, count table memory, outer/inner counters and
// accumulator. Depends on occ_pkg and ordered_composition_counter_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "ordered_composition_counter_macros.svh"

module occ_datapath
    import occ_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_dp_cmd          i_cmd,
    input  wire logic [VAL_W-1:0] i_part_value,
    input  wire logic             i_last_part,
    input  wire logic [TGT_W-1:0] i_target_sum,
    output t_dp_sts               o_sts,
    output logic [WAY_W-1:0]      o_ways,
    output logic                  o_parts_dropped
);

    logic [VAL_W-1:0] r_part [MAX_PARTS];
    logic [CNT_W-1:0] r_count;
    logic             r_ovf;
    logic [TGT_W-1:0] r_target;

    logic [WAY_W-1:0] r_table [MAX_TARGET + 1];
    logic [WAY_W-1:0] r_rd_data;
    logic             r_rd_vld;

    logic [IDX_W-1:0] r_i;
    logic [K_W-1:0]   r_k;
    logic [WAY_W-1:0] r_acc;
    logic [WAY_W-1:0] r_ways;
    logic             r_dropped;

    logic [EW-1:0]    p_ext;
    logic [EW-1:0]    i_ext;
    logic [EW-1:0]    tgt_ext;
    logic             fits;
    logic [IDX_W-1:0] rd_addr;
    logic [WAY_W-1:0] result;

    assign p_ext   = EW'(r_part[r_k]);
    assign i_ext   = EW'(r_i);
    assign tgt_ext = EW'(r_target);
    assign fits    = (p_ext <= i_ext);
    assign rd_addr = IDX_W'(i_ext - p_ext);

    assign o_sts.target_zero = (r_target == '0);
    assign o_sts.target_big  = (int'(r_target) > MAX_TARGET);
    assign o_sts.count_zero  = (r_count == '0);
    assign o_sts.k_last      = (CNT_W'(r_k) == r_count - CNT_W'(1));
    assign o_sts.i_last      = (i_ext == tgt_ext);

    always_comb begin
        if (o_sts.target_big) begin
            result = '0;
        end else if (o_sts.target_zero) begin
            result = WAY_W'(1);
        end else if (o_sts.count_zero) begin
            result = '0;
        end else begin
            result = r_acc;
        end
    end

    // part set: control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.finish) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.load && (i_part_value != '0)) begin
            if (int'(r_count) < MAX_PARTS) begin
                r_count <= r_count + CNT_W'(1);
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (i_part_value != '0) && (int'(r_count) < MAX_PARTS)) begin
            r_part[K_W'(r_count)] <= i_part_value;
        end
        if (i_cmd.load && i_last_part) begin
            r_target <= i_target_sum;
        end
    end

    // count table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_table[0] <= WAY_W'(1);
        end else if (i_cmd.write) begin
            r_table[r_i] <= r_acc;
        end
        r_rd_data <= r_table[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.issue && fits;
        end
    end

    // loop counters and accumulator
    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_i   <= IDX_W'(1);
            r_k   <= '0;
            r_acc <= '0;
        end else begin
            if (i_cmd.issue) begin
                r_k <= o_sts.k_last ? '0 : r_k + K_W'(1);
            end
            if (i_cmd.write) begin
                r_i   <= r_i + IDX_W'(1);
                r_acc <= '0;
            end else if (r_rd_vld) begin
                r_acc <= r_acc + r_rd_data;
            end
        end
        if (i_cmd.finish) begin
            r_ways    <= result;
            r_dropped <= r_ovf;
        end
    end

    assign o_ways          = r_ways;
    assign o_parts_dropped = r_dropped;

    `OCC_ASSERT_NOW(a_count_bound, 1'b1, int'(r_count) <= MAX_PARTS, "part count past store")
    `OCC_ASSERT_NOW(a_issue_k, i_cmd.issue, CNT_W'(r_k) < r_count, "issue past stored parts")
    `OCC_ASSERT_NOW(a_write_idx, i_cmd.write, i_ext <= tgt_ext, "table write past target")

endmodule

`default_nettype wire

// File: rtl/ordered_composition_counter.sv
// Top level of the ordered composition counter.
// Depends on occ_pkg, occ_ctrl and occ_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input channel: a transaction is taken at a rising edge with i_start high
//   and o_busy low. Each carries one part value; a zero value is ignored.
//   Up to MAX_PARTS nonzero parts are kept, further ones are dropped and
//   flagged. The transaction with i_last_part high also brings i_target_sum
//   and starts the count; its own part joins the set first.
//   Result channel: o_valid is high for exactly one cycle with o_ways (ordered
//   compositions of the target, modulo 2^32) and o_parts_dropped. The
//   receiver cannot stall; the result must be taken in that cycle.
//   Throughput: non-final parts load one per cycle with o_busy staying low.
//   A final transaction passes to a decide state, which finishes the count
//   at once when the target is zero or no part is stored, else goes to init
//   and then through issue, wait and write for each table entry up to the
//   target. The count table memory has one read port, so each entry is read
//   once per stored part; the wait lets the last read data land before the write.
//   The part set and the dropped flag clear with each result.
//   Reset (i_rst_n low, synchronous) empties the part set and drops any
//   count in progress; the table holds no state between problems.

module ordered_composition_counter
    import occ_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    output logic                  o_busy,
    input  wire logic [VAL_W-1:0] i_part_value,
    input  wire logic             i_last_part,
    input  wire logic [TGT_W-1:0] i_target_sum,
    output logic                  o_valid,
    output logic [WAY_W-1:0]      o_ways,
    output logic                  o_parts_dropped
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer: owns the handshake and steps the table fill
    occ_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_last_part (i_last_part),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_busy      (o_busy),
        .o_valid     (o_valid)
    );

    // part store, table memory and accumulator
    occ_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_part_value    (i_part_value),
        .i_last_part     (i_last_part),
        .i_target_sum    (i_target_sum),
        .o_sts           (sts),
        .o_ways          (o_ways),
        .o_parts_dropped (o_parts_dropped)
    );

endmodule

`default_nettype wire
